FILE: rtl/core/assert_macros.svh
// assert_macros.svh: clocked assertion macros shared by slp_result_fifo and slp_leaf_core
// no dependencies; pulled in by `include in files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define SLP_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLP_ASSERT(label, clk, rst_n, cond, msg)
`define SLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/slp_pkg.sv
// slp_pkg: shared types and constants of the spatial leaf packer
// no dependencies; imported by the register block, the leaf core, the result queue and the top level
package slp_pkg;

    // configuration port geometry
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // group size register
    localparam int GROUP_BITS = 13;
    localparam logic [GROUP_BITS-1:0] GROUP_SIZE_RST = 13'd64;

    // register indexes, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_GROUP_SIZE  = 1'b0,
        REG_GROWTH_MODE = 1'b1
    } slp_reg_idx_t;

    // live configuration
    typedef struct packed {
        logic [GROUP_BITS-1:0] group_size;
        logic                  growth_mode;
    } slp_cfg_t;

    // result pushes from the leaf core into the result queue
    typedef struct packed {
        logic first;
        logic second;
    } slp_push_t;

endpackage

FILE: rtl/core/slp_if.sv
// slp_if: valid/ready channel interfaces for point items and leaf items
// no dependencies; used by spatial_leaf_packer ports
interface slp_point_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  end_of_set;

    modport source (output valid, pos_x, pos_y, end_of_set, input ready);
    modport sink   (input valid, pos_x, pos_y, end_of_set, output ready);
endinterface

interface slp_leaf_if #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] box_min_x;
    logic [COORD_BITS-1:0] box_min_y;
    logic [COORD_BITS-1:0] box_max_x;
    logic [COORD_BITS-1:0] box_max_y;
    logic [COUNT_BITS-1:0] point_count;
    logic                  last_of_run;

    modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y,
                    point_count, last_of_run, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_max_x, box_max_y,
                    point_count, last_of_run, output ready);
endinterface

FILE: rtl/core/spatial_leaf_packer.sv
// spatial_leaf_packer: top level, groups curve-ordered points into leaf boxes
// depends on slp_pkg, slp_if, slp_cfg_regs, slp_leaf_core and slp_result_fifo
//
//  port       dir   handshake          carries
//  point_in   in    valid/ready        pos_x, pos_y, end_of_set
//  leaf_out   out   valid/ready        box_min/max_x/y, point_count, last_of_run
//  apb        in    psel/penable       group_size (0x0), growth_mode (0x4)
//
// one point per cycle while the queue has room; a point lands in the input register
// at acceptance, and its results pass into the four-entry result queue once room is set
// a point that breaks the growth limit together with end_of_set gives two results;
// the queue drains one result per cycle while ready, so runs of those set the rate
// the input register holds while the queue has fewer than two free entries
// reset clears the open leaf, the queue and the registers; no clearing pass
module spatial_leaf_packer
    import slp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    slp_point_if.sink                point_in,
    slp_leaf_if.source               leaf_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int RES_BITS = 4 * COORD_BITS + COUNT_BITS + 1;

    slp_cfg_t            cfg;
    slp_push_t           push;
    logic                room;
    logic [RES_BITS-1:0] res_first;
    logic [RES_BITS-1:0] res_second;
    logic [RES_BITS-1:0] head;

    // configuration registers
    slp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // leaf decision
    slp_leaf_core #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS),
        .RES_BITS   (RES_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (point_in.valid),
        .in_ready   (point_in.ready),
        .pos_x      (point_in.pos_x),
        .pos_y      (point_in.pos_y),
        .end_of_set (point_in.end_of_set),
        .room       (room),
        .push       (push),
        .res_first  (res_first),
        .res_second (res_second)
    );

    // result queue
    slp_result_fifo #(
        .WIDTH (RES_BITS)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .data_first  (res_first),
        .data_second (res_second),
        .room        (room),
        .out_valid   (leaf_out.valid),
        .out_ready   (leaf_out.ready),
        .out_data    (head)
    );

    // unpack the queue head onto the leaf channel
    assign leaf_out.box_min_x   = head[RES_BITS-1 -: COORD_BITS];
    assign leaf_out.box_min_y   = head[RES_BITS-1-COORD_BITS -: COORD_BITS];
    assign leaf_out.box_max_x   = head[RES_BITS-1-2*COORD_BITS -: COORD_BITS];
    assign leaf_out.box_max_y   = head[RES_BITS-1-3*COORD_BITS -: COORD_BITS];
    assign leaf_out.point_count = head[COUNT_BITS:1];
    assign leaf_out.last_of_run = head[0];

endmodule

FILE: rtl/core/slp_cfg_regs.sv
// slp_cfg_regs: apb register block holding group_size and growth_mode
// depends on slp_pkg
module slp_cfg_regs
    import slp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output slp_cfg_t                 cfg
);

    slp_cfg_t     cfg_reg;
    slp_reg_idx_t idx;
    logic         wr_en;

    assign idx    = slp_reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_size  <= GROUP_SIZE_RST;
            cfg_reg.growth_mode <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GROUP_SIZE:  cfg_reg.group_size  <= pwdata[GROUP_BITS-1:0];
                REG_GROWTH_MODE: cfg_reg.growth_mode <= pwdata[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            REG_GROUP_SIZE:  prdata = APB_DATA_BITS'(cfg_reg.group_size);
            REG_GROWTH_MODE: prdata = APB_DATA_BITS'(cfg_reg.growth_mode);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/slp_result_fifo.sv
// slp_result_fifo: four-entry result queue taking up to two items per cycle
// depends on slp_pkg and assert_macros.svh
`include "assert_macros.svh"

module slp_result_fifo
    import slp_pkg::*;
#(
    parameter int WIDTH = 81
) (
    input  logic             clk,
    input  logic             rst_n,
    input  slp_push_t        push,
    input  logic [WIDTH-1:0] data_first,
    input  logic [WIDTH-1:0] data_second,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                pop;

    // room for two more items, judged on the registered fill only
    assign room      = (cnt_reg <= CNT_BITS'(DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.first) + PTR_BITS'(push.second);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        cnt_next    = cnt_reg + CNT_BITS'(push.first) + CNT_BITS'(push.second)
                      - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_ptr_reg] <= data_first;
        end
        if (push.second)
        begin
            mem[wr_ptr_reg + PTR_BITS'(1)] <= data_second;
        end
    end

    `SLP_ASSERT(a_fill_bound, clk, rst_n, cnt_reg <= CNT_BITS'(DEPTH), "result queue overfilled")
    `SLP_ASSERT_IMP(a_push_room, clk, rst_n, push.first, cnt_reg <= CNT_BITS'(DEPTH - 2), "push without room")
    `SLP_ASSERT_IMP(a_push_order, clk, rst_n, push.second, push.first, "second push alone")

endmodule

FILE: rtl/core/slp_leaf_core.sv
// slp_leaf_core: input register, open-leaf state and the per-point leaf decision
// depends on slp_pkg and assert_macros.svh
`include "assert_macros.svh"

module slp_leaf_core
    import slp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16,
    parameter int RES_BITS   = 4 * 16 + 16 + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slp_cfg_t              cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic                  end_of_set,
    input  logic                  room,
    output slp_push_t             push,
    output logic [RES_BITS-1:0]   res_first,
    output logic [RES_BITS-1:0]   res_second
);

    localparam int AREA_BITS = 2 * COORD_BITS;
    localparam int PROD_BITS = AREA_BITS + 3;
    localparam int CMP_BITS  = (COUNT_BITS > GROUP_BITS) ? COUNT_BITS : GROUP_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // input register
    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [COORD_BITS-1:0] in_x_reg;
    logic [COORD_BITS-1:0] in_y_reg;
    logic                  in_eos_reg;
    logic                  fire;
    logic                  accept;

    // open leaf state
    logic [COORD_BITS-1:0] min_x_reg, min_x_next;
    logic [COORD_BITS-1:0] min_y_reg, min_y_next;
    logic [COORD_BITS-1:0] max_x_reg, max_x_next;
    logic [COORD_BITS-1:0] max_y_reg, max_y_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [AREA_BITS-1:0]  base_reg, base_next;
    logic                  growing_reg, growing_next;

    // decision path
    logic [COORD_BITS-1:0] mx0, mx1, my0, my1;
    logic [COORD_BITS-1:0] dx, dy;
    logic [AREA_BITS-1:0]  area;
    logic [PROD_BITS-1:0]  area5;
    logic [PROD_BITS-1:0]  base6;
    logic [GROUP_BITS-1:0] full;
    logic [GROUP_BITS-2:0] seed;
    logic                  open_now;
    logic                  brk;
    logic                  fresh;
    logic [COUNT_BITS-1:0] count1;
    logic                  growing1;
    logic [AREA_BITS-1:0]  base1;
    logic                  seed_done;
    logic                  close1;

    assign fire     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_vld_next = accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_x_reg   <= pos_x;
            in_y_reg   <= pos_y;
            in_eos_reg <= end_of_set;
        end
    end

    // merged box with the new point and its area
    always_comb
    begin
        mx0   = (in_x_reg < min_x_reg) ? in_x_reg : min_x_reg;
        mx1   = (in_x_reg > max_x_reg) ? in_x_reg : max_x_reg;
        my0   = (in_y_reg < min_y_reg) ? in_y_reg : min_y_reg;
        my1   = (in_y_reg > max_y_reg) ? in_y_reg : max_y_reg;
        dx    = mx1 - mx0;
        dy    = my1 - my0;
        area  = AREA_BITS'(dx) * AREA_BITS'(dy);
        // growth limit area <= 1.2 * base, as area*5 <= base*6
        area5 = {3'b000, area} + {1'b0, area, 2'b00};
        base6 = {1'b0, base_reg, 2'b00} + {2'b00, base_reg, 1'b0};
    end

    // leaf decision for the registered point
    always_comb
    begin
        full = (cfg.group_size == '0) ? GROUP_BITS'(1) : cfg.group_size;
        seed = (cfg.group_size[GROUP_BITS-1:1] == '0) ? (GROUP_BITS-1)'(1)
                                                      : cfg.group_size[GROUP_BITS-1:1];
        open_now = (count_reg == '0);
        brk      = !open_now && cfg.growth_mode && growing_reg && (area5 > base6);
        fresh    = open_now || brk;

        // point taken in or a new leaf opened on it
        if (fresh)
        begin
            min_x_next = in_x_reg;
            max_x_next = in_x_reg;
            min_y_next = in_y_reg;
            max_y_next = in_y_reg;
            count1     = COUNT_BITS'(1);
            growing1   = 1'b0;
            base1      = '0;
        end
        else
        begin
            min_x_next = mx0;
            max_x_next = mx1;
            min_y_next = my0;
            max_y_next = my1;
            count1     = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_BITS'(1);
            growing1   = growing_reg;
            base1      = base_reg;
        end

        // seeding complete: record the base area
        seed_done = cfg.growth_mode && !growing1
                    && (CMP_BITS'(count1) >= CMP_BITS'(seed));
        // fixed-size close or end-of-set flush
        close1 = (!cfg.growth_mode && (CMP_BITS'(count1) >= CMP_BITS'(full))) || in_eos_reg;

        base_next    = seed_done ? (fresh ? '0 : area) : base1;
        growing_next = close1 ? 1'b0 : (seed_done ? 1'b1 : growing1);
        count_next   = close1 ? '0 : count1;

        // results in order: broken leaf first, then the closed one
        if (brk)
        begin
            res_first = {min_x_reg, min_y_reg, max_x_reg, max_y_reg, count_reg, !close1};
        end
        else
        begin
            res_first = {min_x_next, min_y_next, max_x_next, max_y_next, count1, 1'b1};
        end
        res_second   = {min_x_next, min_y_next, max_x_next, max_y_next, count1, 1'b1};
        push.first   = fire && (brk || close1);
        push.second  = fire && brk && close1;
    end

    // leaf state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            max_x_reg   <= '0;
            max_y_reg   <= '0;
            count_reg   <= '0;
            base_reg    <= '0;
            growing_reg <= 1'b0;
        end
        else if (fire)
        begin
            min_x_reg   <= min_x_next;
            min_y_reg   <= min_y_next;
            max_x_reg   <= max_x_next;
            max_y_reg   <= max_y_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            growing_reg <= growing_next;
        end
    end

    `SLP_ASSERT_IMP(a_grow_open, clk, rst_n, growing_reg, count_reg != '0, "growing with no open leaf")
    `SLP_ASSERT_NXT(a_two_clear, clk, rst_n, push.second, count_reg == '0, "leaf left open after flush")
    `SLP_ASSERT_IMP(a_two_mode, clk, rst_n, push.second, cfg.growth_mode, "two results in fixed mode")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of spatial_leaf_packer, points in and leaf boxes out
// depends on slp_pkg, slp_if and the rtl top level; a built-in leaf predictor, or a typed
// result on some directed rows, checks every leaf item, after a directed table and random point sets
module tb
    import slp_pkg::*;
();

    // one expected leaf item
    typedef struct packed {
        logic [15:0] box_min_x;
        logic [15:0] box_min_y;
        logic [15:0] box_max_x;
        logic [15:0] box_max_y;
        logic [15:0] point_count;
        logic        last_of_run;
    } leaf_t;

    // one stimulus step: a register write or a point, optionally with a typed result
    typedef struct {
        bit           is_cfg;
        slp_reg_idx_t reg_idx;
        logic [31:0]  value;
        logic [15:0]  x;
        logic [15:0]  y;
        logic         eos;
        bit           typed;
        bit           typed_n;
        leaf_t        typed_leaf;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    slp_point_if #(.COORD_BITS(16))                  pt_if ();
    slp_leaf_if  #(.COORD_BITS(16), .COUNT_BITS(16)) lf_if ();

    spatial_leaf_packer #(
        .COORD_BITS(16),
        .COUNT_BITS(16)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .point_in(pt_if),
        .leaf_out(lf_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and the open leaf
    logic [12:0]     cfg_group_size;
    logic            cfg_growth_mode;
    logic [15:0]     leaf_min_x;
    logic [15:0]     leaf_min_y;
    logic [15:0]     leaf_max_x;
    logic [15:0]     leaf_max_y;
    logic [15:0]     leaf_count;
    longint unsigned leaf_base_area;
    logic            leaf_growing;

    leaf_t       leaf_expect_q[$];
    leaf_t       leaf_want;
    stim_row_t   stim_table[$];
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned errors;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL spatial_leaf_packer");
        $finish;
    end

    function automatic longint unsigned box_area(input logic [15:0] x0, y0, x1, y1);
        longint unsigned w;
        longint unsigned h;
        w = x1 - x0;
        h = y1 - y0;
        return w * h;
    endfunction

    function automatic void start_leaf(input logic [15:0] x, y);
        leaf_min_x     = x;
        leaf_max_x     = x;
        leaf_min_y     = y;
        leaf_max_y     = y;
        leaf_count     = 16'd1;
        leaf_growing   = 1'b0;
        leaf_base_area = 0;
    endfunction

    function automatic void grow_leaf(input logic [15:0] x, y);
        if (x < leaf_min_x) leaf_min_x = x;
        if (x > leaf_max_x) leaf_max_x = x;
        if (y < leaf_min_y) leaf_min_y = y;
        if (y > leaf_max_y) leaf_max_y = y;
        if (leaf_count != 16'hFFFF) leaf_count = leaf_count + 16'd1;
    endfunction

    // append one expected leaf item
    function automatic void expect_leaf(input leaf_t lf);
        leaf_expect_q.insert(leaf_expect_q.size(), lf);
    endfunction

    function automatic void close_leaf();
        expect_leaf('{leaf_min_x, leaf_min_y, leaf_max_x, leaf_max_y, leaf_count, 1'b0});
        leaf_count   = 16'd0;
        leaf_growing = 1'b0;
    endfunction

    // leaf predictor: one accepted point, its closed leaves go to leaf_expect_q
    function automatic void pack_point(input logic [15:0] x, y, input logic eos);
        int unsigned depth;
        int unsigned full;
        int unsigned seed;
        logic [15:0] nx0;
        logic [15:0] nx1;
        logic [15:0] ny0;
        logic [15:0] ny1;
        depth = leaf_expect_q.size();
        full  = (cfg_group_size < 1) ? 1 : cfg_group_size;
        seed  = cfg_group_size / 2;
        if (seed < 1) seed = 1;

        if (leaf_count == 0)
            start_leaf(x, y);
        else if (cfg_growth_mode && leaf_growing)
        begin
            nx0 = (x < leaf_min_x) ? x : leaf_min_x;
            nx1 = (x > leaf_max_x) ? x : leaf_max_x;
            ny0 = (y < leaf_min_y) ? y : leaf_min_y;
            ny1 = (y > leaf_max_y) ? y : leaf_max_y;
            // grown area within 1.2x of the seed area
            if (box_area(nx0, ny0, nx1, ny1) * 5 <= leaf_base_area * 6)
                grow_leaf(x, y);
            else
            begin
                close_leaf();
                start_leaf(x, y);
            end
        end
        else
            grow_leaf(x, y);

        if (!cfg_growth_mode)
        begin
            if (leaf_count >= full) close_leaf();
        end
        else if (!leaf_growing && leaf_count != 0 && leaf_count >= seed)
        begin
            leaf_base_area = box_area(leaf_min_x, leaf_min_y, leaf_max_x, leaf_max_y);
            leaf_growing   = 1'b1;
        end

        if (eos && leaf_count != 0) close_leaf();

        // mark the final item of this point
        if (leaf_expect_q.size() > depth)
            leaf_expect_q[leaf_expect_q.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic stim_row_t cfg_row(input slp_reg_idx_t idx, input logic [31:0] val);
        stim_row_t r;
        r = '{reg_idx: REG_GROUP_SIZE, default: 0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    function automatic stim_row_t pt_row(input logic [15:0] x, y, input logic eos);
        stim_row_t r;
        r = '{reg_idx: REG_GROUP_SIZE, default: 0};
        r.reg_idx = REG_GROUP_SIZE;
        r.x       = x;
        r.y       = y;
        r.eos     = eos;
        return r;
    endfunction

    // point whose outcome is typed in: no item, or one leaf ending the run
    function automatic stim_row_t exp_row(input logic [15:0] x, y, input logic eos,
                                          input bit n, input logic [15:0] mnx, mny,
                                          mxx, mxy, cnt);
        stim_row_t r;
        r = pt_row(x, y, eos);
        r.typed      = 1'b1;
        r.typed_n    = n;
        r.typed_leaf = '{mnx, mny, mxx, mxy, cnt, 1'b1};
        return r;
    endfunction

    // append one stimulus row
    function automatic void add_row(input stim_row_t r);
        stim_table.insert(stim_table.size(), r);
    endfunction

    // register write, only with nothing in flight
    task automatic program_reg(input slp_reg_idx_t idx, input logic [31:0] val);
        while (leaf_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_GROUP_SIZE)
            cfg_group_size = val[12:0];
        else
            cfg_growth_mode = val[0];
    endtask

    // drive one point item; predict at acceptance
    task automatic send_point(input stim_row_t r);
        int unsigned depth;
        while ($urandom_range(99) < src_idle_pct)
        begin
            pt_if.valid = 1'b0;
            @(negedge clk);
        end
        pt_if.valid      = 1'b1;
        pt_if.pos_x      = r.x;
        pt_if.pos_y      = r.y;
        pt_if.end_of_set = r.eos;
        @(posedge clk);
        while (!pt_if.ready) @(posedge clk);
        depth = leaf_expect_q.size();
        pack_point(r.x, r.y, r.eos);
        if (r.typed)
        begin
            while (leaf_expect_q.size() > depth) void'(leaf_expect_q.pop_back());
            if (r.typed_n) expect_leaf(r.typed_leaf);
        end
        @(negedge clk);
        pt_if.valid = 1'b0;
    endtask

    // random point sets: mostly local walks, some jumps and corners
    task automatic random_sets(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        int unsigned stp;
        int          cx;
        int          cy;
        logic [31:0] gs;
        logic        eos;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                gs = 4096;
            else if (pick < 7)
                gs = 8191;
            else if (pick < 11)
                gs = $urandom_range(1);
            else
                gs = $urandom_range(12, 2);
            program_reg(REG_GROUP_SIZE, gs);
            program_reg(REG_GROWTH_MODE, $urandom_range(1));
            len = (gs > 64) ? $urandom_range(40, 1) : $urandom_range(3 * gs + 8, 1);
            cx  = $urandom_range(65535);
            cy  = $urandom_range(65535);
            stp = 1 << $urandom_range(12);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    cx = $urandom_range(65535);
                    cy = $urandom_range(65535);
                end
                else if (pick < 25)
                begin
                    cx = $urandom_range(1) ? 65535 : 0;
                    cy = $urandom_range(1) ? 65535 : 0;
                end
                else
                begin
                    cx = cx + int'($urandom_range(2 * stp)) - int'(stp);
                    cy = cy + int'($urandom_range(2 * stp)) - int'(stp);
                    if (cx < 0) cx = 0;
                    if (cx > 65535) cx = 65535;
                    if (cy < 0) cy = 0;
                    if (cy > 65535) cy = 65535;
                end
                if (i == len - 1)
                    eos = ($urandom_range(99) < 85);
                else
                    eos = ($urandom_range(99) < 3);
                send_point(pt_row(cx[15:0], cy[15:0], eos));
                sent++;
            end
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want, got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // receiver stalls
    always @(negedge clk)
        lf_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    // leaf item checker
    always @(posedge clk)
    begin
        if (rst_n && lf_if.valid && lf_if.ready)
        begin
            if (leaf_expect_q.size() == 0)
            begin
                $error("leaf item with none expected");
                errors++;
            end
            else
            begin
                leaf_want = leaf_expect_q.pop_front();
                check_field("box_min_x", leaf_want.box_min_x, lf_if.box_min_x);
                check_field("box_min_y", leaf_want.box_min_y, lf_if.box_min_y);
                check_field("box_max_x", leaf_want.box_max_x, lf_if.box_max_x);
                check_field("box_max_y", leaf_want.box_max_y, lf_if.box_max_y);
                check_field("point_count", leaf_want.point_count, lf_if.point_count);
                check_field("last_of_run", leaf_want.last_of_run, lf_if.last_of_run);
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pt_if.valid      = 1'b0;
        pt_if.pos_x      = '0;
        pt_if.pos_y      = '0;
        pt_if.end_of_set = 1'b0;
        lf_if.ready      = 1'b0;
        errors           = 0;
        src_idle_pct     = 22;
        snk_idle_pct     = 50;
        cfg_group_size   = GROUP_SIZE_RST;
        cfg_growth_mode  = 1'b0;
        leaf_min_x       = '0;
        leaf_min_y       = '0;
        leaf_max_x       = '0;
        leaf_max_y       = '0;
        leaf_count       = '0;
        leaf_base_area   = 0;
        leaf_growing     = 1'b0;

        // fixed mode: extremes, flush, tiny group sizes
        add_row(cfg_row(REG_GROUP_SIZE, 2));
        add_row(exp_row(16'h0000, 16'h0000, 1'b0, 1'b0, 0, 0, 0, 0, 0));
        add_row(exp_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b1,
                        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd2));
        add_row(exp_row(16'h5555, 16'hAAAA, 1'b1, 1'b1,
                        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'd1));
        add_row(cfg_row(REG_GROUP_SIZE, 1));
        add_row(exp_row(16'hAAAA, 16'h5555, 1'b0, 1'b1,
                        16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'd1));
        add_row(cfg_row(REG_GROUP_SIZE, 0));
        add_row(exp_row(16'h1234, 16'hFFFF, 1'b1, 1'b1,
                        16'h1234, 16'hFFFF, 16'h1234, 16'hFFFF, 16'd1));
        // heuristic: growth exactly at the limit, then a break and a flush
        add_row(cfg_row(REG_GROUP_SIZE, 4));
        add_row(cfg_row(REG_GROWTH_MODE, 1));
        add_row(pt_row(16'd100, 16'd100, 1'b0));
        add_row(pt_row(16'd110, 16'd110, 1'b0));
        add_row(pt_row(16'd112, 16'd105, 1'b0));
        add_row(pt_row(16'd100, 16'd112, 1'b0));
        add_row(pt_row(16'd90, 16'd112, 1'b1));
        // zero seed area, then a limit break together with end of set
        add_row(pt_row(16'd5, 16'd5, 1'b0));
        add_row(pt_row(16'd5, 16'd5, 1'b0));
        add_row(pt_row(16'd5, 16'd9, 1'b0));
        add_row(pt_row(16'd6, 16'd9, 1'b0));
        add_row(pt_row(16'd7, 16'd9, 1'b0));
        add_row(pt_row(16'd8, 16'd10, 1'b1));
        // seed of one point
        add_row(cfg_row(REG_GROUP_SIZE, 1));
        add_row(pt_row(16'h0000, 16'h0000, 1'b0));
        add_row(pt_row(16'hFFFF, 16'hFFFF, 1'b1));
        // mode change with a leaf open
        add_row(cfg_row(REG_GROUP_SIZE, 4));
        add_row(pt_row(16'd1, 16'd1, 1'b0));
        add_row(pt_row(16'd2, 16'd2, 1'b0));
        add_row(cfg_row(REG_GROWTH_MODE, 0));
        add_row(pt_row(16'd3, 16'd3, 1'b0));
        add_row(pt_row(16'd4, 16'd4, 1'b0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                program_reg(stim_table[i].reg_idx, stim_table[i].value);
            else
                send_point(stim_table[i]);
        end

        random_sets(140);
        src_idle_pct = 50;
        snk_idle_pct = 22;
        random_sets(140);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_sets(140);

        // drain
        while (leaf_expect_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS spatial_leaf_packer");
        else
            $display("FAIL spatial_leaf_packer");
        $finish;
    end

endmodule
